// ----- rtl/core/mlbe_pkg.sv -----
// ---------------------------------------------------------------------------
// mlbe_pkg
// shared types, constants and tables for the morse letter blink encoder:
// register indexes and reset values, the letter table and the control store
// ---------------------------------------------------------------------------
package mlbe_pkg;

  localparam int DurW  = 24;
  localparam int CharW = 8;

  typedef logic [DurW-1:0]  dur_t;
  typedef logic [CharW-1:0] char_t;

  // register indexes on the configuration port
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_DOT      = 2'd0;
  localparam reg_idx_t REG_DASH     = 2'd1;
  localparam reg_idx_t REG_SYM_GAP  = 2'd2;
  localparam reg_idx_t REG_WORD_GAP = 2'd3;

  localparam dur_t DOT_RESET      = 24'd200000;
  localparam dur_t DASH_RESET     = 24'd400000;
  localparam dur_t SYM_GAP_RESET  = 24'd700000;
  localparam dur_t WORD_GAP_RESET = 24'd3000000;

  localparam char_t CHAR_A     = 8'd65;
  localparam char_t CHAR_Z     = 8'd90;
  localparam char_t CHAR_SPACE = 8'd32;

  // symbol count and dash mask, bit k set means symbol k is a dash
  typedef logic [2:0] sym_cnt_t;
  typedef logic [3:0] sym_pat_t;

  typedef struct packed {
    sym_cnt_t cnt;
    sym_pat_t pat;
  } letter_t;

  function automatic letter_t letter_lookup(input logic [4:0] idx);
    letter_t l;
    case (idx)
      5'd0:  l = '{3'd2, 4'd2};   // a
      5'd1:  l = '{3'd4, 4'd1};   // b
      5'd2:  l = '{3'd4, 4'd5};   // c
      5'd3:  l = '{3'd3, 4'd1};   // d
      5'd4:  l = '{3'd1, 4'd0};   // e
      5'd5:  l = '{3'd4, 4'd4};   // f
      5'd6:  l = '{3'd3, 4'd3};   // g
      5'd7:  l = '{3'd4, 4'd0};   // h
      5'd8:  l = '{3'd2, 4'd0};   // i
      5'd9:  l = '{3'd4, 4'd14};  // j
      5'd10: l = '{3'd3, 4'd5};   // k
      5'd11: l = '{3'd4, 4'd2};   // l
      5'd12: l = '{3'd2, 4'd3};   // m
      5'd13: l = '{3'd2, 4'd1};   // n
      5'd14: l = '{3'd3, 4'd7};   // o
      5'd15: l = '{3'd4, 4'd6};   // p
      5'd16: l = '{3'd4, 4'd11};  // q
      5'd17: l = '{3'd3, 4'd2};   // r
      5'd18: l = '{3'd3, 4'd0};   // s
      5'd19: l = '{3'd1, 4'd1};   // t
      5'd20: l = '{3'd3, 4'd4};   // u
      5'd21: l = '{3'd4, 4'd8};   // v
      5'd22: l = '{3'd3, 4'd6};   // w
      5'd23: l = '{3'd4, 4'd9};   // x
      5'd24: l = '{3'd4, 4'd13};  // y
      5'd25: l = '{3'd4, 4'd3};   // z
      default: l = '{3'd1, 4'd0};
    endcase
    return l;
  endfunction

  // microcode step addresses
  typedef logic [1:0] step_t;
  localparam step_t STEP_IDLE  = 2'd0;
  localparam step_t STEP_LIT   = 2'd1;
  localparam step_t STEP_GAP   = 2'd2;
  localparam step_t STEP_SPACE = 2'd3;

  typedef enum logic [1:0] {
    DUR_SYM  = 2'd0,
    DUR_GAP  = 2'd1,
    DUR_WORD = 2'd2
  } dur_sel_t;

  typedef enum logic [1:0] {
    LAST_NO    = 2'd0,
    LAST_YES   = 2'd1,
    LAST_FINAL = 2'd2
  } last_sel_t;

  typedef enum logic [1:0] {
    COND_SEQ      = 2'd0,
    COND_FINAL    = 2'd1,
    COND_DISPATCH = 2'd2
  } cond_t;

  typedef struct packed {
    logic      ready;    // step may take a new character
    logic      emit;     // a run goes out this cycle
    logic      led;
    dur_sel_t  dur_sel;
    last_sel_t last_sel;
    logic      advance;  // retire one symbol
    cond_t     cond;
    step_t     target;   // taken jump
    step_t     next;     // fall-through
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      STEP_IDLE:  w = '{1'b1, 1'b0, 1'b0, DUR_SYM,  LAST_NO,    1'b0,
                        COND_DISPATCH, STEP_LIT, STEP_IDLE};
      STEP_LIT:   w = '{1'b0, 1'b1, 1'b1, DUR_SYM,  LAST_NO,    1'b0,
                        COND_SEQ, STEP_GAP, STEP_GAP};
      STEP_GAP:   w = '{1'b0, 1'b1, 1'b0, DUR_GAP,  LAST_FINAL, 1'b1,
                        COND_FINAL, STEP_IDLE, STEP_LIT};
      STEP_SPACE: w = '{1'b0, 1'b1, 1'b0, DUR_WORD, LAST_YES,   1'b0,
                        COND_SEQ, STEP_IDLE, STEP_IDLE};
      default:    w = '{1'b1, 1'b0, 1'b0, DUR_SYM,  LAST_NO,    1'b0,
                        COND_SEQ, STEP_IDLE, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/morse_letter_blink_encoder.sv -----
// ---------------------------------------------------------------------------
// morse_letter_blink_encoder
// turns one character code into timed led runs in international morse
// ---------------------------------------------------------------------------
// usage:
//   a character word is taken at a rising edge where start is high and busy
//   is low. upper-case a..z gives, per symbol, a lit run (dot or dash ticks)
//   then a dark run (symbol gap ticks); a space gives one dark run of word
//   gap ticks; any other byte is taken and dropped with no runs.
//   each run shows on led_on / duration / last for exactly one cycle with
//   strobe high; last marks the final run of the character. the receiver
//   cannot stall, so runs go out back to back, one per cycle.
// sequencing:
//   the first run appears in the cycle after the accepting edge. a letter
//   keeps busy high while its lit and dark runs go out, a space while its
//   one dark run goes out. a new character is taken only in the idle step;
//   a dropped byte keeps it idle. each busy control step issues one run.
// configuration:
//   cfg_we / cfg_index / cfg_data write the tick registers one at a time,
//   all 24 bits are kept; write them only while busy is low.
// reset:
//   rst (synchronous) returns the sequencer to its idle step and loads the
//   default tick values 200000 / 400000 / 700000 / 3000000.
// ---------------------------------------------------------------------------
module morse_letter_blink_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mlbe_pkg::char_t   char_code,
  output logic              busy,
  output logic              strobe,
  output logic              led_on,
  output mlbe_pkg::dur_t    duration,
  output logic              last,
  input  logic              cfg_we,
  input  mlbe_pkg::reg_idx_t cfg_index,
  input  mlbe_pkg::dur_t    cfg_data
);
  import mlbe_pkg::*;

  // tick registers
  dur_t dot_ticks;
  dur_t dash_ticks;
  dur_t sym_gap_ticks;
  dur_t word_gap_ticks;

  // sequencer and symbol datapath
  step_t    step;
  step_t    step_next;
  sym_cnt_t sym_left;
  sym_cnt_t sym_left_next;
  sym_pat_t sym_pat;
  sym_pat_t sym_pat_next;

  ucode_t  uw;
  logic    accept;
  logic    is_letter;
  logic    is_space;
  logic    final_sym;
  letter_t letter;
  char_t   letter_off;

  assign uw = ucode_rom(step);

  assign accept     = start && uw.ready;
  assign is_letter  = (char_code >= CHAR_A) && (char_code <= CHAR_Z);
  assign is_space   = (char_code == CHAR_SPACE);
  assign letter_off = char_code - CHAR_A;
  assign letter     = letter_lookup(letter_off[4:0]);
  assign final_sym  = (sym_left == 3'd1);

  // result word, straight from the control word, symbol and tick registers
  assign busy   = !uw.ready;
  assign strobe = uw.emit;
  assign led_on = uw.led;

  always_comb begin
    case (uw.dur_sel)
      DUR_SYM:  duration = sym_pat[0] ? dash_ticks : dot_ticks;
      DUR_GAP:  duration = sym_gap_ticks;
      DUR_WORD: duration = word_gap_ticks;
      default:  duration = sym_gap_ticks;
    endcase
  end

  always_comb begin
    case (uw.last_sel)
      LAST_NO:    last = 1'b0;
      LAST_YES:   last = 1'b1;
      LAST_FINAL: last = final_sym;
      default:    last = 1'b0;
    endcase
  end

  // next step: sequential, jump on final symbol, or dispatch on a new word
  always_comb begin
    case (uw.cond)
      COND_SEQ:   step_next = uw.next;
      COND_FINAL: step_next = final_sym ? uw.target : uw.next;
      COND_DISPATCH: begin
        if (accept && is_letter) begin
          step_next = uw.target;
        end else if (accept && is_space) begin
          step_next = STEP_SPACE;
        end else begin
          step_next = uw.next;
        end
      end
      default:    step_next = STEP_IDLE;
    endcase
  end

  // symbol count and dash mask: load on a letter, shift out per gap run
  always_comb begin
    sym_left_next = sym_left;
    sym_pat_next  = sym_pat;
    if (accept && is_letter) begin
      sym_left_next = letter.cnt;
      sym_pat_next  = letter.pat;
    end else if (uw.advance) begin
      sym_left_next = sym_left - 3'd1;
      sym_pat_next  = {1'b0, sym_pat[3:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    sym_left <= sym_left_next;
    sym_pat  <= sym_pat_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks      <= DOT_RESET;
      dash_ticks     <= DASH_RESET;
      sym_gap_ticks  <= SYM_GAP_RESET;
      word_gap_ticks <= WORD_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOT:      dot_ticks      <= cfg_data;
        REG_DASH:     dash_ticks     <= cfg_data;
        REG_SYM_GAP:  sym_gap_ticks  <= cfg_data;
        REG_WORD_GAP: word_gap_ticks <= cfg_data;
        default:      ;
      endcase
    end
  end

endmodule

// ----- sim/tb_morse_letter_blink_encoder.sv -----
// ---------------------------------------------------------------------------
// tb_morse_letter_blink_encoder
// self-checking bench for the morse letter blink encoder: character words go
// in through the start/busy handshake, every led run that comes out on the
// strobe is compared with a run list predicted from a morse table kept here,
// across reset tick values, zero, full-scale, small distinct and random ticks
// ---------------------------------------------------------------------------

class blink_run_board;

  typedef struct packed {
    logic           led;
    mlbe_pkg::dur_t dur;
    logic           fin;
  } run_t;

  localparam byte DashMark = "-";

  run_t           runs_due[$];
  string          code_of[26];
  mlbe_pkg::dur_t dot_len;
  mlbe_pkg::dur_t dash_len;
  mlbe_pkg::dur_t gap_len;
  mlbe_pkg::dur_t word_len;
  int             errors;
  int             runs_seen;
  int             chars_seen;

  function new();
    code_of = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
    dot_len    = 24'd200000;
    dash_len   = 24'd400000;
    gap_len    = 24'd700000;
    word_len   = 24'd3000000;
    errors     = 0;
    runs_seen  = 0;
    chars_seen = 0;
  endfunction

  function void set_reg(mlbe_pkg::reg_idx_t idx, mlbe_pkg::dur_t val);
    case (idx)
      mlbe_pkg::REG_DOT:      dot_len  = val;
      mlbe_pkg::REG_DASH:     dash_len = val;
      mlbe_pkg::REG_SYM_GAP:  gap_len  = val;
      mlbe_pkg::REG_WORD_GAP: word_len = val;
      default: ;
    endcase
  endfunction

  function void add_run(logic led, mlbe_pkg::dur_t dur, logic fin);
    run_t r;
    r.led = led;
    r.dur = dur;
    r.fin = fin;
    runs_due.push_back(r);
  endfunction

  // expected runs for one accepted character word
  function void note_char(mlbe_pkg::char_t c);
    string sym;
    int    i;
    chars_seen++;
    if (c >= mlbe_pkg::CHAR_A && c <= mlbe_pkg::CHAR_Z) begin
      sym = code_of[c - mlbe_pkg::CHAR_A];
      for (i = 0; i < sym.len(); i++) begin
        add_run(1'b1, (sym[i] == DashMark) ? dash_len : dot_len, 1'b0);
        add_run(1'b0, gap_len, (i == sym.len() - 1));
      end
    end else if (c == mlbe_pkg::CHAR_SPACE) begin
      add_run(1'b0, word_len, 1'b1);
    end
  endfunction

  function void check_run(logic led, mlbe_pkg::dur_t dur, logic fin);
    run_t want;
    runs_seen++;
    if (runs_due.size() == 0) begin
      $error("unexpected run: led_on %0d duration %0d last %0d", led, dur, fin);
      errors++;
      return;
    end
    want = runs_due.pop_front();
    if (led !== want.led) begin
      $error("led_on: expected %0d, actual %0d", want.led, led);
      errors++;
    end
    if (dur !== want.dur) begin
      $error("duration: expected %0d, actual %0d", want.dur, dur);
      errors++;
    end
    if (fin !== want.fin) begin
      $error("last: expected %0d, actual %0d", want.fin, fin);
      errors++;
    end
  endfunction

endclass

module tb_morse_letter_blink_encoder;

  timeunit 1ns;
  timeprecision 1ps;

  import mlbe_pkg::*;

  // cycles with neither a word taken nor a run out before giving up
  localparam int QuietLimit = 500;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  char_t    char_code = '0;
  logic     busy;
  logic     strobe;
  logic     led_on;
  dur_t     duration;
  logic     last;
  logic     cfg_we = 1'b0;
  reg_idx_t cfg_index = REG_DOT;
  dur_t     cfg_data = '0;

  blink_run_board board = new();
  int             quiet_cycles = 0;
  int             settings_used = 1;   // reset values count as the first

  morse_letter_blink_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .char_code (char_code),
    .busy      (busy),
    .strobe    (strobe),
    .led_on    (led_on),
    .duration  (duration),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // runs are sampled mid-cycle, well away from the edge that drives inputs
  always @(negedge clk) begin
    if (!rst && strobe) begin
      board.check_run(led_on, duration, last);
    end
  end

  // watchdog: a hung handshake or a run that never comes ends the run here
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QuietLimit) begin
        $display("watchdog: %0d quiet cycles, %0d runs still due",
                 QuietLimit, board.runs_due.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // present one character word and hold it until the edge that takes it;
  // start is left high so a following word can go out back to back
  task automatic send_char(input char_t c);
    start <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_char(c);
  endtask

  // sender idles for the given number of cycles with noise on the character bus
  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    char_code <= char_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // sender holds off until every predicted run has come out and the block
  // is idle again, and waits on past that since a dropped byte leaves no run
  task automatic drain();
    start <= 1'b0;
    char_code <= char_t'($urandom);
    @(posedge clk);
    while (board.runs_due.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write all four tick registers, one per cycle, only while idle
  task automatic program_ticks(input dur_t dot, input dur_t dash, input dur_t gap,
                               input dur_t word);
    reg_idx_t order [4];
    dur_t     vals  [4];
    int       i;
    order = '{REG_DOT, REG_DASH, REG_SYM_GAP, REG_WORD_GAP};
    vals  = '{dot, dash, gap, word};
    cfg_we <= 1'b1;
    for (i = 0; i < 4; i++) begin
      cfg_index <= order[i];
      cfg_data <= vals[i];
      @(posedge clk);
      board.set_reg(order[i], vals[i]);
    end
    cfg_we <= 1'b0;
    cfg_data <= dur_t'($urandom);
    @(posedge clk);
    settings_used++;
  endtask

  // mostly letters, some spaces, the rest any byte (lower case, digits,
  // punctuation, codes above 127), most of which the block should drop silently
  function automatic char_t pick_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return char_t'(CHAR_A + $urandom_range(25));
    if (roll < 75) return CHAR_SPACE;
    return char_t'($urandom_range(255));
  endfunction

  // after each word: each cycle the sender could present, it holds off with
  // the given odds, and once per random phase with idling a full hold-off until the
  // block has emptied
  task automatic after_word(input int idle_pct, input bit hold_off);
    int gap;
    gap = 0;
    if (hold_off) begin
      drain();
    end else if (idle_pct > 0) begin
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
        idle_gap(gap);
      end
    end
  endtask

  task automatic random_burst(input int count, input int idle_pct);
    int n;
    for (n = 0; n < count; n++) begin
      send_char(pick_char());
      after_word(idle_pct, (idle_pct > 0) && (n == count / 2));
    end
  endtask

  initial begin
    char_t directed [];
    int    n;

    // extremes of the byte, longest and shortest letters, a space, and
    // neighbors of the letter range that must be dropped
    directed = '{CHAR_A, CHAR_Z, "E", "T", "J", "Q", "Y", "H", "O", CHAR_SPACE,
                 8'd0, 8'd255, 8'd64, 8'd91, 8'd31, 8'd33, "a", "z", "M",
                 CHAR_SPACE, 8'd170, 8'd85, "B"};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset tick values
    for (n = 0; n < directed.size(); n++) begin
      send_char(directed[n]);
      after_word(9, 1'b0);
    end
    drain();

    // zero ticks still give every run, with duration 0
    program_ticks('0, '0, '0, '0);
    random_burst(60, 9);
    drain();

    // full-scale ticks, heavy sender idling
    program_ticks('1, '1, '1, '1);
    random_burst(60, 77);
    drain();

    // random ticks, no idling: words go out back to back
    program_ticks(dur_t'($urandom), dur_t'($urandom), dur_t'($urandom),
                  dur_t'($urandom));
    random_burst(70, 0);
    drain();

    // small distinct ticks so a swapped register shows at once
    program_ticks(24'd1, 24'd2, 24'd3, 24'd4);
    random_burst(60, 0);
    drain();

    repeat (10) @(posedge clk);

    $display("sent %0d character words over %0d tick settings, %0d led runs compared",
             board.chars_seen, settings_used, board.runs_seen);
    $display("idling: light and heavy sender gaps, back-to-back words, full hold-offs");
    if (board.errors == 0 && board.runs_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- morse_letter_blink_encoder.f -----
rtl/core/mlbe_pkg.sv
rtl/core/morse_letter_blink_encoder.sv
sim/tb_morse_letter_blink_encoder.sv
